// ===== design/awvn_pkg.sv =====
// Shared types and constants for the area-weighted vertex normal block.
// Depends on nothing; used by awvn_div and area_weighted_vertex_normals_top.
`default_nettype none

package awvn_pkg;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_FACE  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam int INDEX_W   = 10;
   localparam int POS_W     = 16;
   localparam int NRM_W     = 16;
   localparam int AREA_W    = 35;
   localparam int NSUM_W    = 56;
   localparam int ASUM_W    = 40;
   localparam int MAG_W     = 40;   // component bound after the pre-shift
   localparam int HALF_W    = 20;   // half of a pre-shifted magnitude
   localparam int ROOT_W    = 42;
   localparam int SQ_W      = 2 * ROOT_W;
   localparam int MUL_W     = 26;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int K_W       = 5;
   localparam int QB_W      = 6;
   localparam int DIV_NUM_W = 56;
   localparam int NRM_FRAC  = 14;
   localparam int NRM_QBITS = 15;
   localparam int ONE_Q14   = 16384;
   localparam int AREA_LO_W = 18;
   // x / 3 with x = hi * 2^18 + lo: hi * (2^18 - 1) / 3 plus (hi + lo) / 3
   localparam int THIRD_HI_MUL = 87381;
   localparam int THIRD_LO_MUL = 699051;   // ceil(2^21 / 3), exact below 2^19
   localparam int THIRD_LO_SH  = 21;

   typedef struct packed {
      logic [1:0]                operation;
      logic [INDEX_W-1:0]        index_a;
      logic [INDEX_W-1:0]        index_b;
      logic [INDEX_W-1:0]        index_c;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
   } req_type;

   typedef struct packed {
      logic signed [NRM_W-1:0]   normal_x;
      logic signed [NRM_W-1:0]   normal_y;
      logic signed [NRM_W-1:0]   normal_z;
      logic [AREA_W-1:0]         area;
      logic                      degenerate;
   } rsp_type;

   typedef struct packed {
      logic                      start;
      logic [ROOT_W-1:0]         divisor;
      logic [DIV_NUM_W-1:0]      numer;
      logic [QB_W-1:0]           qbits;
   } div_req_type;

   typedef struct packed {
      logic                      busy;
      logic                      done;
      logic [AREA_W-1:0]         quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== design/awvn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on awvn_pkg; the caller guarantees numer >> qbits is below the divisor.
`default_nettype none

module awvn_div (
   input  wire                  clock,
   input  wire                  reset,
   input  awvn_pkg::div_req_type req,
   output awvn_pkg::div_rsp_type rsp
);
   import awvn_pkg::*;

   logic [ROOT_W-1:0]    rem_ff;
   logic [ROOT_W-1:0]    dvs_ff;
   logic [DIV_NUM_W-1:0] sh_ff;
   logic [AREA_W-1:0]    quot_ff;
   logic [QB_W-1:0]      cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [ROOT_W:0]      trial;
   logic                 ge;

   assign trial = {rem_ff, sh_ff[DIV_NUM_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.qbits;
            dvs_ff  <= req.divisor;
            rem_ff  <= ROOT_W'(req.numer >> req.qbits);
            sh_ff   <= req.numer << (7'(DIV_NUM_W) - {1'b0, req.qbits});
            quot_ff <= '0;
         end else if (busy_ff) begin
            rem_ff  <= ge ? ROOT_W'(trial - {1'b0, dvs_ff}) : trial[ROOT_W-1:0];
            quot_ff <= {quot_ff[AREA_W-2:0], ge};
            sh_ff   <= sh_ff << 1;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == QB_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

// ===== design/area_weighted_vertex_normals_top.sv =====
// Top level of the area-weighted vertex normal block: sequencer, shared multiplier, memories.
// Depends on awvn_pkg and awvn_div.
`default_nettype none

// One item is handled at a time; req_ready is high only while the sequencer is idle.
// After reset a clearing pass writes zero to every accumulator row before the first item
// is taken; csr writes are taken throughout. k (0..16) is the pre-shift, in bits, that
// brings the largest component below 2^40. The sequencer walks one 26x26 multiplier
// (cross products, squares, normal-times-area products, each as a multiply state and an
// accumulate state), a 42-step bitwise square root, and one shared restoring divider,
// used once per normal component. When a face updates the vertex sums (it is not
// degenerate and the csr keep bit is clear), the third of the area takes two more
// multiplier passes and a sum, and the face then runs three read-modify-write passes
// over the accumulator memory. Indices at or beyond VERTEX_COUNT are folded by repeated
// subtraction (no fold when VERTEX_COUNT is 1024 or more). A result sits in an
// output register; the sequencer only stalls when it has a new result and the old one
// has not been taken.
module area_weighted_vertex_normals_top #(
   parameter int VERTEX_COUNT = 1024,
   parameter int COORD_BITS   = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  awvn_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output awvn_pkg::rsp_type    rsp_payload,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire                  csr_data
);
   import awvn_pkg::*;

   localparam int ADDR_W = $clog2(VERTEX_COUNT);
   localparam int DW     = COORD_BITS + 1;
   localparam int PW     = 3 * COORD_BITS;
   localparam int NS1_W  = NSUM_W + 1;
   localparam int AS_W   = ROOT_W + (2 ** K_W) - 1;
   localparam int RT_W   = ROOT_W + 4;
   localparam int RR_W   = ROOT_W + 2;

   typedef struct packed {
      logic signed [NSUM_W-1:0] sx;
      logic signed [NSUM_W-1:0] sy;
      logic signed [NSUM_W-1:0] sz;
      logic [ASUM_W-1:0]        sa;
   } acc_row_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_REDUCE, S_PWRITE, S_PREAD, S_DIFF, S_XMUL, S_XACC,
      S_ARD, S_AWAIT, S_MAG, S_SHIFT, S_SQMUL, S_SQACC, S_ROOT, S_DIVGO,
      S_DIVWAIT, S_AREA, S_EMIT, S_PMUL, S_PACC, S_THIRD_HI, S_THIRD_LO,
      S_THIRD_SUM, S_CRD, S_CWB
   } state_type;

   state_type                 state_ff;
   logic [ADDR_W-1:0]         clr_ff;
   logic [5:0]                st_ff;
   logic [1:0]                sub_ff;
   logic                      keep_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   req_type                   req_ff;
   logic [INDEX_W-1:0]        idx_ff [3];
   logic signed [COORD_BITS-1:0] pt_ff [3][3];
   logic signed [DW-1:0]      d1_ff [3];
   logic signed [DW-1:0]      d2_ff [3];
   logic signed [NSUM_W-1:0]  c_ff [3];
   logic [NSUM_W-1:0]         m_ff [3];
   logic                      neg_ff [3];
   logic [K_W-1:0]            k_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [SQ_W-1:0]           rad_ff;
   logic [RR_W-1:0]           rt_rem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic signed [NRM_W-1:0]   n_ff [3];
   logic                      deg_ff;
   logic [AREA_W-1:0]         area_ff;
   logic [ASUM_W-1:0]         asum_ff;
   logic signed [NSUM_W-1:0]  p_ff [3];
   logic [AREA_W-1:0]         third_ff;
   logic signed [PROD_W-1:0]  prod_ff;

   logic [PW-1:0]             pos_mem [VERTEX_COUNT];
   logic [PW-1:0]             pos_q;
   acc_row_type               acc_mem [VERTEX_COUNT];
   acc_row_type               acc_q;

   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic [2:0]                over;
   logic [1:0]                sel3;
   logic [1:0]                corner_sel;
   logic [ADDR_W-1:0]         pos_raddr;
   logic                      pos_we;
   logic [PW-1:0]             pos_wdata;
   logic [ADDR_W-1:0]         acc_raddr;
   logic [ADDR_W-1:0]         acc_waddr;
   logic                      acc_we;
   acc_row_type               acc_wdata;
   logic [SQ_W-1:0]           sq_in;
   logic [RT_W-1:0]           rt_trial;
   logic [RT_W-1:0]           rt_test;
   logic                      rt_ge;
   logic [ROOT_W-1:0]         root_in;
   logic [AS_W-1:0]           area_shift;
   logic [AREA_W-1:0]         face_area;
   logic [AREA_W-1:0]         read_area;
   logic                      big;
   logic [ASUM_W:0]           asum_in;
   logic [AREA_W:0]           third_x;
   logic [AREA_LO_W:0]        third_y;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   function automatic logic signed [NSUM_W-1:0] sat_nsum(input logic signed [NS1_W-1:0] t);
      logic signed [NSUM_W-1:0] r;
      r = t[NSUM_W-1:0];
      if (t[NS1_W-1] != t[NSUM_W-1])
         r = t[NS1_W-1] ? {1'b1, {(NSUM_W-1){1'b0}}} : {1'b0, {(NSUM_W-1){1'b1}}};
      return r;
   endfunction

   awvn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // handshake
   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // index folding
   always_comb begin
      for (int i = 0; i < 3; i++)
         over[i] = 32'(idx_ff[i]) >= 32'(VERTEX_COUNT);
   end

   assign sel3       = (st_ff[1:0] == 2'd3) ? 2'd0 : st_ff[1:0];
   assign corner_sel = (state_ff == S_CRD || state_ff == S_CWB) ? sel3 : 2'd0;

   // position memory
   assign pos_raddr = ADDR_W'(idx_ff[sel3]);
   assign pos_we    = (state_ff == S_PWRITE);
   assign pos_wdata = {COORD_BITS'($unsigned(req_ff.pos_x)),
                       COORD_BITS'($unsigned(req_ff.pos_y)),
                       COORD_BITS'($unsigned(req_ff.pos_z))};

   always_ff @(posedge clock) begin
      if (pos_we)
         pos_mem[ADDR_W'(idx_ff[0])] <= pos_wdata;
      pos_q <= pos_mem[pos_raddr];
   end

   // accumulator memory: saturating read-modify-write per corner
   assign acc_raddr = ADDR_W'(idx_ff[corner_sel]);
   assign asum_in   = {1'b0, acc_q.sa} + (ASUM_W + 1)'(third_ff);

   always_comb begin
      acc_we    = 1'b0;
      acc_waddr = acc_raddr;
      acc_wdata = '0;
      if (state_ff == S_CLEAR) begin
         acc_we    = 1'b1;
         acc_waddr = clr_ff;
      end else if (state_ff == S_CWB) begin
         acc_we       = 1'b1;
         acc_wdata.sx = sat_nsum(NS1_W'(acc_q.sx) + NS1_W'(p_ff[0]));
         acc_wdata.sy = sat_nsum(NS1_W'(acc_q.sy) + NS1_W'(p_ff[1]));
         acc_wdata.sz = sat_nsum(NS1_W'(acc_q.sz) + NS1_W'(p_ff[2]));
         acc_wdata.sa = asum_in[ASUM_W] ? {ASUM_W{1'b1}} : asum_in[ASUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we)
         acc_mem[acc_waddr] <= acc_wdata;
      acc_q <= acc_mem[acc_raddr];
   end

   // rounded third of the area: split at 2^18, since 2^18 leaves 1 modulo 3
   assign third_x = {1'b0, area_ff} + (AREA_W + 1)'(1);
   assign third_y = (AREA_LO_W + 1)'(third_x[AREA_W:AREA_LO_W]) +
                    (AREA_LO_W + 1)'(third_x[AREA_LO_W-1:0]);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_XMUL: begin
            case (st_ff[2:0])
               3'd0:    begin mul_a = MUL_W'(d1_ff[1]); mul_b = MUL_W'(d2_ff[2]); end
               3'd1:    begin mul_a = MUL_W'(d1_ff[2]); mul_b = MUL_W'(d2_ff[1]); end
               3'd2:    begin mul_a = MUL_W'(d1_ff[2]); mul_b = MUL_W'(d2_ff[0]); end
               3'd3:    begin mul_a = MUL_W'(d1_ff[0]); mul_b = MUL_W'(d2_ff[2]); end
               3'd4:    begin mul_a = MUL_W'(d1_ff[0]); mul_b = MUL_W'(d2_ff[1]); end
               3'd5:    begin mul_a = MUL_W'(d1_ff[1]); mul_b = MUL_W'(d2_ff[0]); end
               default: ;
            endcase
         end
         S_SQMUL: begin
            case (sub_ff)
               2'd0: begin
                  mul_a = MUL_W'(m_ff[sel3][MAG_W-1:HALF_W]);
                  mul_b = MUL_W'(m_ff[sel3][MAG_W-1:HALF_W]);
               end
               2'd1: begin
                  mul_a = MUL_W'(m_ff[sel3][MAG_W-1:HALF_W]);
                  mul_b = MUL_W'(m_ff[sel3][HALF_W-1:0]);
               end
               default: begin
                  mul_a = MUL_W'(m_ff[sel3][HALF_W-1:0]);
                  mul_b = MUL_W'(m_ff[sel3][HALF_W-1:0]);
               end
            endcase
         end
         S_PMUL: begin
            mul_a = MUL_W'(n_ff[st_ff[2:1]]);
            mul_b = st_ff[0] ? MUL_W'(area_ff[AREA_W-1:AREA_LO_W])
                             : MUL_W'(area_ff[AREA_LO_W-1:0]);
         end
         S_THIRD_HI: begin
            mul_a = MUL_W'(third_x[AREA_W:AREA_LO_W]);
            mul_b = MUL_W'(THIRD_HI_MUL);
         end
         S_THIRD_LO: begin
            mul_a = MUL_W'(third_y);
            mul_b = MUL_W'(THIRD_LO_MUL);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock)
      prod_ff <= mul_a * mul_b;

   // sum of squares: hi*hi at 2^40, hi*lo twice at 2^20, lo*lo
   always_comb begin
      case (sub_ff)
         2'd0:    sq_in = sq_ff + (SQ_W'(prod_ff[MAG_W-1:0]) << (2 * HALF_W));
         2'd1:    sq_in = sq_ff + (SQ_W'(prod_ff[MAG_W-1:0]) << (HALF_W + 1));
         default: sq_in = sq_ff + SQ_W'(prod_ff[MAG_W-1:0]);
      endcase
   end

   // one bit of the square root per cycle
   assign rt_trial = {rt_rem_ff, rad_ff[SQ_W-1 -: 2]};
   assign rt_test  = RT_W'({root_ff, 2'b01});
   assign rt_ge    = rt_trial >= rt_test;
   assign root_in  = {root_ff[ROOT_W-2:0], rt_ge};

   assign big = (m_ff[0][NSUM_W-1:MAG_W] != '0) || (m_ff[1][NSUM_W-1:MAG_W] != '0) ||
                (m_ff[2][NSUM_W-1:MAG_W] != '0);

   assign area_shift = AS_W'(root_ff) << k_ff;
   assign face_area  = (area_shift[AS_W-1:AREA_W] != '0) ? {AREA_W{1'b1}}
                                                         : area_shift[AREA_W-1:0];
   assign read_area  = (asum_ff[ASUM_W-1:AREA_W] != '0) ? {AREA_W{1'b1}}
                                                         : asum_ff[AREA_W-1:0];

   // divider requests
   always_comb begin
      div_req = '0;
      if (state_ff == S_DIVGO) begin
         div_req.start   = 1'b1;
         div_req.divisor = root_ff;
         div_req.numer   = (DIV_NUM_W'(m_ff[sel3][MAG_W-1:0]) << NRM_FRAC) +
                           DIV_NUM_W'(root_ff >> 1);
         div_req.qbits   = QB_W'(NRM_QBITS);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         st_ff        <= '0;
         sub_ff       <= '0;
         keep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid)
            keep_ff <= csr_data;
         // drop the result once the transfer completes; the emit state sets it itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_EMIT)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               if (clr_ff == ADDR_W'(VERTEX_COUNT - 1))
                  state_ff <= S_IDLE;
               clr_ff <= clr_ff + 1'b1;
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_payload;
                  idx_ff[0] <= req_payload.index_a;
                  idx_ff[1] <= req_payload.index_b;
                  idx_ff[2] <= req_payload.index_c;
                  if (req_payload.operation == OP_WRITE || req_payload.operation == OP_FACE ||
                      req_payload.operation == OP_READ)
                     state_ff <= S_REDUCE;
               end
            end
            S_REDUCE: begin
               for (int i = 0; i < 3; i++)
                  if (over[i])
                     idx_ff[i] <= idx_ff[i] - INDEX_W'(VERTEX_COUNT);
               if (over == 3'b000) begin
                  st_ff <= '0;
                  case (req_ff.operation)
                     OP_WRITE: state_ff <= S_PWRITE;
                     OP_FACE:  state_ff <= S_PREAD;
                     default:  state_ff <= S_ARD;
                  endcase
               end
            end
            S_PWRITE: state_ff <= S_IDLE;
            S_PREAD: begin
               if (st_ff != '0) begin
                  pt_ff[st_ff[1:0] - 2'd1][0] <= pos_q[PW-1 -: COORD_BITS];
                  pt_ff[st_ff[1:0] - 2'd1][1] <= pos_q[2*COORD_BITS-1 -: COORD_BITS];
                  pt_ff[st_ff[1:0] - 2'd1][2] <= pos_q[COORD_BITS-1:0];
               end
               if (st_ff == 6'd3)
                  state_ff <= S_DIFF;
               st_ff <= st_ff + 1'b1;
            end
            S_DIFF: begin
               for (int i = 0; i < 3; i++) begin
                  d1_ff[i] <= DW'(pt_ff[1][i]) - DW'(pt_ff[0][i]);
                  d2_ff[i] <= DW'(pt_ff[2][i]) - DW'(pt_ff[0][i]);
                  c_ff[i]  <= '0;
               end
               st_ff    <= '0;
               state_ff <= S_XMUL;
            end
            S_XMUL: state_ff <= S_XACC;
            S_XACC: begin
               if (st_ff[0])
                  c_ff[st_ff[2:1]] <= c_ff[st_ff[2:1]] - NSUM_W'(prod_ff);
               else
                  c_ff[st_ff[2:1]] <= c_ff[st_ff[2:1]] + NSUM_W'(prod_ff);
               st_ff    <= st_ff + 1'b1;
               state_ff <= (st_ff == 6'd5) ? S_MAG : S_XMUL;
            end
            S_ARD: state_ff <= S_AWAIT;
            S_AWAIT: begin
               c_ff[0]  <= acc_q.sx;
               c_ff[1]  <= acc_q.sy;
               c_ff[2]  <= acc_q.sz;
               asum_ff  <= acc_q.sa;
               state_ff <= S_MAG;
            end
            S_MAG: begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i]   <= c_ff[i][NSUM_W-1] ? NSUM_W'(-c_ff[i]) : NSUM_W'(c_ff[i]);
                  neg_ff[i] <= c_ff[i][NSUM_W-1];
               end
               k_ff     <= '0;
               state_ff <= S_SHIFT;
            end
            S_SHIFT: begin
               if (big) begin
                  for (int i = 0; i < 3; i++)
                     m_ff[i] <= m_ff[i] >> 1;
                  k_ff <= k_ff + 1'b1;
               end else begin
                  sq_ff    <= '0;
                  st_ff    <= '0;
                  sub_ff   <= '0;
                  state_ff <= S_SQMUL;
               end
            end
            S_SQMUL: state_ff <= S_SQACC;
            S_SQACC: begin
               sq_ff <= sq_in;
               if (sub_ff == 2'd2) begin
                  sub_ff <= '0;
                  if (st_ff == 6'd2) begin
                     rad_ff    <= sq_in;
                     rt_rem_ff <= '0;
                     root_ff   <= '0;
                     st_ff     <= '0;
                     state_ff  <= S_ROOT;
                  end else begin
                     st_ff    <= st_ff + 1'b1;
                     state_ff <= S_SQMUL;
                  end
               end else begin
                  sub_ff   <= sub_ff + 1'b1;
                  state_ff <= S_SQMUL;
               end
            end
            S_ROOT: begin
               rt_rem_ff <= rt_ge ? RR_W'(rt_trial - rt_test) : rt_trial[RR_W-1:0];
               root_ff   <= root_in;
               rad_ff    <= rad_ff << 2;
               if (st_ff == 6'(ROOT_W - 1)) begin
                  st_ff <= '0;
                  if (root_in == '0) begin
                     // zero-length vector: normal zeroed and flagged
                     for (int i = 0; i < 3; i++)
                        n_ff[i] <= '0;
                     deg_ff   <= 1'b1;
                     state_ff <= S_AREA;
                  end else begin
                     deg_ff   <= 1'b0;
                     state_ff <= S_DIVGO;
                  end
               end else begin
                  st_ff <= st_ff + 1'b1;
               end
            end
            S_DIVGO: state_ff <= S_DIVWAIT;
            S_DIVWAIT: begin
               if (div_rsp.done) begin
                  n_ff[sel3] <= neg_ff[sel3] ? -NRM_W'(div_rsp.quot[NRM_QBITS-1:0])
                                             :  NRM_W'(div_rsp.quot[NRM_QBITS-1:0]);
                  st_ff      <= st_ff + 1'b1;
                  state_ff   <= (st_ff == 6'd2) ? S_AREA : S_DIVGO;
               end
            end
            S_AREA: begin
               area_ff  <= (req_ff.operation == OP_FACE) ? face_area : read_area;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               // hold here while the previous result is still waiting
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.normal_x     <= n_ff[0];
                  rsp_ff.normal_y     <= n_ff[1];
                  rsp_ff.normal_z     <= n_ff[2];
                  rsp_ff.area         <= area_ff;
                  rsp_ff.degenerate   <= deg_ff;
                  if (req_ff.operation == OP_FACE && !deg_ff && !keep_ff) begin
                     for (int i = 0; i < 3; i++)
                        p_ff[i] <= '0;
                     st_ff    <= '0;
                     state_ff <= S_PMUL;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_PMUL: state_ff <= S_PACC;
            S_PACC: begin
               if (st_ff[0])
                  p_ff[st_ff[2:1]] <= p_ff[st_ff[2:1]] + (NSUM_W'(prod_ff) << AREA_LO_W);
               else
                  p_ff[st_ff[2:1]] <= p_ff[st_ff[2:1]] + NSUM_W'(prod_ff);
               st_ff    <= st_ff + 1'b1;
               state_ff <= (st_ff == 6'd5) ? S_THIRD_HI : S_PMUL;
            end
            S_THIRD_HI: state_ff <= S_THIRD_LO;
            S_THIRD_LO: begin
               third_ff <= AREA_W'(prod_ff[AREA_W-1:0]);
               state_ff <= S_THIRD_SUM;
            end
            S_THIRD_SUM: begin
               third_ff <= third_ff + AREA_W'(prod_ff[PROD_W-1:THIRD_LO_SH]);
               st_ff    <= '0;
               state_ff <= S_CRD;
            end
            S_CRD: state_ff <= S_CWB;
            S_CWB: begin
               // write-back happens this cycle; advance to the next corner
               st_ff    <= st_ff + 1'b1;
               state_ff <= (st_ff == 6'd2) ? S_IDLE : S_CRD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_mag_preshift: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQMUL |-> !big)
      else $error("magnitude above 2^40 after pre-shift");

   a_unit_quot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVWAIT && div_rsp.done) |-> div_rsp.quot <= AREA_W'(ONE_Q14))
      else $error("normal component quotient above one");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.degenerate) |->
         (rsp_ff.normal_x == '0 && rsp_ff.normal_y == '0 && rsp_ff.normal_z == '0))
      else $error("degenerate result with nonzero normal");
`endif

endmodule

`default_nettype wire

// ===== bench/area_weighted_vertex_normals_top_test.sv =====
// Self-checking bench for area_weighted_vertex_normals_top: face, write and read transfers
// checked against a fixed-point normal/area tracker. Depends on awvn_pkg and the RTL only.
module area_weighted_vertex_normals_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import awvn_pkg::*;

   localparam int VCOUNT = 1024;
   localparam longint unsigned AREA_CAP = (64'd1 << 35) - 1;
   localparam longint unsigned ASUM_CAP = (64'd1 << 40) - 1;
   localparam longint NSUM_HI = (64'sd1 <<< 55) - 1;
   localparam longint NSUM_LO = -(64'sd1 <<< 55);
   localparam int SETTLE_CYCLES = 400;   // longer than one face plus the index fold
   localparam logic [1:0] OP_SPARE = 2'd3;  // unused code, dropped by the block

   // Tracks positions and per-vertex sums; one expected response per face or read.
   class vertex_normal_tracker;
      longint pos_x[VCOUNT], pos_y[VCOUNT], pos_z[VCOUNT];
      longint sum_x[VCOUNT], sum_y[VCOUNT], sum_z[VCOUNT];
      longint unsigned area_sum[VCOUNT];
      bit keep_given;
      rsp_type expected_rsp_q[$];
      int errors;

      function void set_keep(bit v);
         keep_given = v;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      // Pre-shift, integer square root of the sum of squares, rounded Q1.14 quotients.
      function longint unsigned normalize(input longint c[3], output longint n[3],
                                          output int k);
         bit [63:0] m[3];
         bit [63:0] mx, r, t, q;
         bit [127:0] ss, t2;
         int sh;
         for (int i = 0; i < 3; i++) m[i] = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
         mx = m[0] > m[1] ? m[0] : m[1];
         if (m[2] > mx) mx = m[2];
         sh = 0;
         while ((mx >> sh) >= (64'd1 << 40)) sh++;
         ss = '0;
         for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            ss += 128'(m[i]) * 128'(m[i]);
         end
         r = '0;
         for (int b = 41; b >= 0; b--) begin
            t = r | (64'd1 << b);
            t2 = 128'(t) * 128'(t);
            if (t2 <= ss) r = t;
         end
         for (int i = 0; i < 3; i++) begin
            if (r == 0) begin
               n[i] = 0;
            end else begin
               q = ((m[i] << 14) + (r >> 1)) / r;
               n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
            end
         end
         k = sh;
         return r;
      endfunction

      function longint clamp_sum(longint s, longint d);
         longint t;
         t = s + d;
         if (t > NSUM_HI) return NSUM_HI;
         if (t < NSUM_LO) return NSUM_LO;
         return t;
      endfunction

      function void note_transfer(req_type q);
         int ia, ib, ic, k, v;
         int corner[3];
         longint d1[3], d2[3], cr[3], n[3], s[3];
         longint unsigned len, area, third, acc;
         rsp_type e;
         ia = q.index_a % VCOUNT;
         ib = q.index_b % VCOUNT;
         ic = q.index_c % VCOUNT;
         case (q.operation)
            OP_WRITE: begin
               pos_x[ia] = longint'($signed(q.pos_x));
               pos_y[ia] = longint'($signed(q.pos_y));
               pos_z[ia] = longint'($signed(q.pos_z));
            end
            OP_FACE: begin
               d1[0] = pos_x[ib] - pos_x[ia];  d2[0] = pos_x[ic] - pos_x[ia];
               d1[1] = pos_y[ib] - pos_y[ia];  d2[1] = pos_y[ic] - pos_y[ia];
               d1[2] = pos_z[ib] - pos_z[ia];  d2[2] = pos_z[ic] - pos_z[ia];
               cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
               cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
               cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
               len = normalize(cr, n, k);
               area = (len > (AREA_CAP >> k)) ? AREA_CAP : (len << k);
               e.normal_x = 16'(n[0]);
               e.normal_y = 16'(n[1]);
               e.normal_z = 16'(n[2]);
               e.area = 35'(area);
               e.degenerate = (len == 0);
               expected_rsp_q.push_back(e);
               if (len != 0 && !keep_given) begin
                  third = (area + 1) / 3;
                  corner[0] = ia; corner[1] = ib; corner[2] = ic;
                  for (int i = 0; i < 3; i++) begin
                     v = corner[i];
                     sum_x[v] = clamp_sum(sum_x[v], n[0] * longint'(area));
                     sum_y[v] = clamp_sum(sum_y[v], n[1] * longint'(area));
                     sum_z[v] = clamp_sum(sum_z[v], n[2] * longint'(area));
                     acc = area_sum[v] + third;
                     area_sum[v] = (acc > ASUM_CAP) ? ASUM_CAP : acc;
                  end
               end
            end
            OP_READ: begin
               s[0] = sum_x[ia];
               s[1] = sum_y[ia];
               s[2] = sum_z[ia];
               len = normalize(s, n, k);
               e.normal_x = 16'(n[0]);
               e.normal_y = 16'(n[1]);
               e.normal_z = 16'(n[2]);
               e.area = 35'((area_sum[ia] > AREA_CAP) ? AREA_CAP : area_sum[ia]);
               e.degenerate = (len == 0);
               expected_rsp_q.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_rsp_q.size() == 0) begin
            $error("response transfer with nothing outstanding");
            errors++;
            return;
         end
         e = expected_rsp_q.pop_front();
         if (got.normal_x !== e.normal_x) begin
            $error("normal_x expected %0d actual %0d", e.normal_x, got.normal_x);
            errors++;
         end
         if (got.normal_y !== e.normal_y) begin
            $error("normal_y expected %0d actual %0d", e.normal_y, got.normal_y);
            errors++;
         end
         if (got.normal_z !== e.normal_z) begin
            $error("normal_z expected %0d actual %0d", e.normal_z, got.normal_z);
            errors++;
         end
         if (got.area !== e.area) begin
            $error("area expected %0d actual %0d", e.area, got.area);
            errors++;
         end
         if (got.degenerate !== e.degenerate) begin
            $error("degenerate expected %0d actual %0d", e.degenerate, got.degenerate);
            errors++;
         end
      endfunction
   endclass

   bit clock = 0;
   bit reset = 1;
   bit req_valid = 0;
   wire req_ready;
   req_type req_payload = '0;
   wire rsp_valid;
   bit rsp_ready = 0;
   rsp_type rsp_payload;
   bit csr_valid = 0;
   wire csr_ready;
   bit csr_data = 0;

   vertex_normal_tracker tracker = new();
   bit calm = 0;              // when set, neither side inserts idle cycles
   bit written[VCOUNT];
   int written_q[$];

   area_weighted_vertex_normals_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Offer one request; hold valid and payload until the transfer happens.
   // Valid is only dropped ahead of a gap, so back-to-back items never toggle it.
   task automatic send_item(req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      tracker.note_transfer(r);
      if (r.operation == OP_WRITE && !written[r.index_a]) begin
         written[r.index_a] = 1;
         written_q.push_back(r.index_a);
      end
   endtask

   // Drop valid and hold until every outstanding response has been returned,
   // then let the last write or dropped item drain out of the sequencer.
   task automatic drain();
      req_valid <= 0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(bit v);
      drain();
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      tracker.set_keep(v);
   endtask

   function automatic req_type make_item(logic [1:0] op, int a, int b, int c,
                                         int x, int y, int z);
      req_type r;
      r.operation = op;
      r.index_a = a[INDEX_W-1:0];
      r.index_b = b[INDEX_W-1:0];
      r.index_c = c[INDEX_W-1:0];
      r.pos_x = x[POS_W-1:0];
      r.pos_y = y[POS_W-1:0];
      r.pos_z = z[POS_W-1:0];
      return r;
   endfunction

   function automatic int pick_coord(int mode);
      case (mode)
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 511) - 256;
         default: begin
            case ($urandom_range(0, 3))
               0: return -32768;
               1: return 32767;
               2: return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   function automatic int pick_vertex();
      return written_q[$urandom_range(0, written_q.size() - 1)];
   endfunction

   // Faces over stored vertices, mixed with writes, reads and spare codes; unused fields carry random bits.
   task automatic random_items(int count);
      int done_cnt, sel, mode;
      req_type r;
      done_cnt = 0;
      while (done_cnt < count) begin
         if (done_cnt % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) == 0) drain();
         r = make_item(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), pick_coord(0), pick_coord(0),
                       pick_coord(0));
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            mode = $urandom_range(0, 2);
            r.pos_x = POS_W'(pick_coord(mode));
            r.pos_y = POS_W'(pick_coord(mode));
            r.pos_z = POS_W'(pick_coord(mode));
         end else if (sel < 75) begin
            r.operation = OP_FACE;
            r.index_a = INDEX_W'(pick_vertex());
            r.index_b = INDEX_W'(pick_vertex());
            r.index_c = INDEX_W'(pick_vertex());
         end else if (sel < 95) begin
            r.operation = OP_READ;
            if (sel < 88) r.index_a = INDEX_W'(pick_vertex());
         end else begin
            r.operation = OP_SPARE;
         end
         send_item(r);
         if (r.operation != OP_SPARE) done_cnt++;
      end
   endtask

   // Response side: random stall per transfer, checked at the accepting edge.
   initial begin : rsp_side
      int stall;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_result(rsp_payload);
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 0;
      write_keep(0);

      // Directed: corner coordinates, top index, degenerate and collinear faces,
      // reads of untouched vertices, and the spare operation code.
      send_item(make_item(OP_WRITE, 0, 0, 0, -32768, -32768, -32768));
      send_item(make_item(OP_WRITE, 1, 0, 0, 32767, -32768, -32768));
      send_item(make_item(OP_WRITE, 2, 0, 0, -32768, 32767, -32768));
      send_item(make_item(OP_WRITE, 3, 0, 0, -32768, -32768, 32767));
      send_item(make_item(OP_WRITE, 1023, 1023, 1023, 32767, 32767, 32767));
      send_item(make_item(OP_WRITE, 5, 0, 0, -16384, -16384, -32768));
      send_item(make_item(OP_WRITE, 6, 0, 0, 0, 0, -32768));
      send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_FACE, 0, 1, 2, 0, 0, 0));
      send_item(make_item(OP_FACE, 0, 2, 1, 0, 0, 0));
      send_item(make_item(OP_FACE, 1, 2, 3, 0, 0, 0));
      send_item(make_item(OP_FACE, 1023, 1, 2, 0, 0, 0));
      send_item(make_item(OP_FACE, 0, 0, 1, 0, 0, 0));
      send_item(make_item(OP_FACE, 0, 5, 6, 0, 0, 0));
      send_item(make_item(OP_FACE, 3, 3, 3, 0, 0, 0));
      send_item(make_item(OP_SPARE, 1023, 1023, 1023, -1, -1, -1));
      send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_READ, 1, 0, 0, 0, 0, 0));
      send_item(make_item(OP_READ, 5, 0, 0, 0, 0, 0));
      send_item(make_item(OP_READ, 1023, 1023, 1023, 0, 0, 0));
      send_item(make_item(OP_READ, 700, 0, 0, 0, 0, 0));

      write_keep(1);
      send_item(make_item(OP_FACE, 1, 2, 3, 0, 0, 0));
      send_item(make_item(OP_READ, 1, 0, 0, 0, 0, 0));
      random_items(300);

      // Hammer one large face so both normal-sum limits and the area limit are hit.
      write_keep(0);
      send_item(make_item(OP_WRITE, 1000, 0, 0, -32768, -32768, -32768));
      send_item(make_item(OP_WRITE, 1001, 0, 0, -32768, -32768, 32767));
      send_item(make_item(OP_WRITE, 1002, 0, 0, 32767, 32767, -32768));
      for (int i = 0; i < 560; i++) begin
         case (i % 3)
            0: send_item(make_item(OP_FACE, 1000, 1001, 1002, 0, 0, 0));
            1: send_item(make_item(OP_FACE, 1001, 1002, 1000, 0, 0, 0));
            default: send_item(make_item(OP_FACE, 1002, 1000, 1001, 0, 0, 0));
         endcase
         if (i % 40 == 39) send_item(make_item(OP_READ, 1000 + (i % 3), 0, 0, 0, 0, 0));
      end
      random_items(500);

      write_keep(1);
      random_items(200);
      write_keep(0);
      random_items(250);

      drain();
      if (tracker.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/awvn_pkg.sv
design/awvn_div.sv
design/area_weighted_vertex_normals_top.sv
bench/area_weighted_vertex_normals_top_test.sv
